### hdl/hmad_pkg.sv
// ----------------------------------------------------------------------------
// Heatmap argmax decoder package
// Shared constants, register indexes, controller states and the command and
// status records that join the controller and the datapath.
// ----------------------------------------------------------------------------
package hmad_pkg;

  // Default sizing of the top level.
  localparam int unsigned MAX_MAP_DIM_DEF   = 256;
  localparam int unsigned MAX_KEYPOINTS_DEF = 64;

  // Fixed field widths.
  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned SCORE_W  = 13;
  localparam int unsigned FRAC_W   = 16;
  localparam int unsigned KPIDX_W  = 6;
  localparam int unsigned CFG_W    = 9;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned KPCNT_W  = 7;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_MAP_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAP_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KP_COUNT   = 2'd2;

  // Configuration register reset values.
  localparam logic [CFG_W-1:0]   MAP_WIDTH_RST  = 9'd64;
  localparam logic [CFG_W-1:0]   MAP_HEIGHT_RST = 9'd64;
  localparam logic [KPCNT_W-1:0] KP_COUNT_RST   = 7'd17;

  // A score of 1.0 in Q1.12.
  localparam logic [SCORE_W-1:0] SCORE_ONE = 13'd4096;

  typedef enum logic [1:0] {
    ST_RUN,
    ST_DIV,
    ST_LOAD
  } hmad_state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;  // A sample is taken this cycle.
    logic start;   // The sample ends a map: capture the result and load the dividers.
    logic step;    // One quotient bit of both divisions.
    logic load;    // Move the finished result into the output register.
  } hmad_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic map_end;   // The current sample is the last of its map.
    logic out_free;  // The output register can take a new result this cycle.
  } hmad_stat_t;

endpackage

### hdl/hmad_div_lane.sv
// ----------------------------------------------------------------------------
// Heatmap argmax decoder divider lane
// Restoring divider that produces one quotient bit per step.
// ----------------------------------------------------------------------------
module hmad_div_lane #(
  parameter int unsigned NUM_W = 24,
  parameter int unsigned DEN_W = 9
) (
  input  logic             clk_i,
  input  logic             start_i,
  input  logic             step_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic [NUM_W-1:0] quo_o
);

  logic [NUM_W-1:0] num_q, num_d;
  logic [NUM_W-1:0] quo_q, quo_d;
  logic [DEN_W-1:0] den_q, den_d;
  logic [DEN_W-1:0] rem_q, rem_d;
  logic [DEN_W:0]   trial;
  logic [DEN_W-1:0] diff;
  logic             ge;

  always_comb begin
    trial = {rem_q, num_q[NUM_W-1]};
    ge    = (trial >= {1'b0, den_q});
    diff  = trial[DEN_W-1:0] - den_q;
    num_d = num_q;
    quo_d = quo_q;
    den_d = den_q;
    rem_d = rem_q;
    if (start_i) begin
      num_d = num_i;
      den_d = den_i;
      rem_d = '0;
      quo_d = '0;
    end else if (step_i) begin
      num_d = {num_q[NUM_W-2:0], 1'b0};
      quo_d = {quo_q[NUM_W-2:0], ge};
      // The remainder stays below the divisor, so the top bit is always zero.
      rem_d = ge ? diff : trial[DEN_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    quo_q <= quo_d;
    den_q <= den_d;
    rem_q <= rem_d;
  end

  assign quo_o = quo_q;

endmodule

### hdl/hmad_datapath.sv
// ----------------------------------------------------------------------------
// Heatmap argmax decoder datapath
// Configuration registers, position counters, running maximum, the two
// normalizing dividers and the output register.
// ----------------------------------------------------------------------------
module hmad_datapath #(
  parameter int unsigned MAX_MAP_DIM   = hmad_pkg::MAX_MAP_DIM_DEF,
  parameter int unsigned MAX_KEYPOINTS = hmad_pkg::MAX_KEYPOINTS_DEF
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_we_i,
  input  logic [hmad_pkg::CFG_IDX_W-1:0]        cfg_index_i,
  input  logic [hmad_pkg::CFG_W-1:0]            cfg_wdata_i,
  input  logic signed [hmad_pkg::SAMPLE_W-1:0]  sample_i,
  input  logic                                  sample_is_nan_i,
  input  logic                                  out_ready_i,
  input  hmad_pkg::hmad_cmd_t                   cmd_i,
  output hmad_pkg::hmad_stat_t                  stat_o,
  output logic                                  out_valid_o,
  output logic [hmad_pkg::KPIDX_W-1:0]          keypoint_index_o,
  output logic [hmad_pkg::SCORE_W-1:0]          score_o,
  output logic [hmad_pkg::FRAC_W-1:0]           x_norm_o,
  output logic [hmad_pkg::FRAC_W-1:0]           y_norm_o,
  output logic                                  last_keypoint_o
);

  import hmad_pkg::*;

  localparam int unsigned POS_W = $clog2(MAX_MAP_DIM);
  localparam int unsigned DIM_W = $clog2(MAX_MAP_DIM + 1);
  localparam int unsigned KP_W  = (MAX_KEYPOINTS > 1) ? $clog2(MAX_KEYPOINTS) : 1;
  localparam int unsigned Q_W   = POS_W + FRAC_W;

  // Configuration registers.
  logic [CFG_W-1:0]   map_width_q, map_height_q;
  logic [KPCNT_W-1:0] kp_count_q;

  // Search state.
  logic [POS_W-1:0]           cur_col_q, cur_row_q;
  logic [KP_W-1:0]            cur_kp_q;
  logic signed [SAMPLE_W-1:0] best_val_q, best_val_d;
  logic [POS_W-1:0]           best_col_q, best_col_d, best_row_q, best_row_d;
  logic                       nan_seen_q, nan_seen_d;

  // Result held while the dividers run, and the output register.
  logic [KPIDX_W-1:0] pend_kp_q;
  logic [SCORE_W-1:0] pend_score_q;
  logic               pend_last_q;
  logic               out_valid_q;
  logic [KPIDX_W-1:0] out_kp_q;
  logic [SCORE_W-1:0] out_score_q;
  logic [FRAC_W-1:0]  out_x_q, out_y_q;
  logic               out_last_q;

  logic [31:0]      eff_w, eff_h, eff_k;
  logic             first, take, last_col, last_row, last_kp;
  logic [SCORE_W-1:0] score_d;
  logic [Q_W-1:0]   quo_x, quo_y;

  // Out-of-range sizes: zero acts as one, anything above the maximum as the maximum.
  always_comb begin
    eff_w = 32'(map_width_q);
    if (eff_w == 32'd0) eff_w = 32'd1;
    else if (eff_w > MAX_MAP_DIM) eff_w = MAX_MAP_DIM;
    eff_h = 32'(map_height_q);
    if (eff_h == 32'd0) eff_h = 32'd1;
    else if (eff_h > MAX_MAP_DIM) eff_h = MAX_MAP_DIM;
    eff_k = 32'(kp_count_q);
    if (eff_k == 32'd0) eff_k = 32'd1;
    else if (eff_k > MAX_KEYPOINTS) eff_k = MAX_KEYPOINTS;
  end

  always_comb begin
    first    = (cur_col_q == '0) && (cur_row_q == '0);
    take     = first || (!nan_seen_q && (sample_is_nan_i || (sample_i > best_val_q)));
    last_col = (32'(cur_col_q) + 32'd1) >= eff_w;
    last_row = (32'(cur_row_q) + 32'd1) >= eff_h;
    last_kp  = (32'(cur_kp_q) + 32'd1) >= eff_k;

    best_val_d = best_val_q;
    best_col_d = best_col_q;
    best_row_d = best_row_q;
    nan_seen_d = nan_seen_q;
    if (take) begin
      best_val_d = sample_i;
      nan_seen_d = sample_is_nan_i;
      best_col_d = first ? '0 : cur_col_q;
      best_row_d = first ? '0 : cur_row_q;
    end

    if (nan_seen_d || best_val_d[SAMPLE_W-1]) begin
      score_d = '0;
    end else if (best_val_d > $signed({3'b000, SCORE_ONE})) begin
      score_d = SCORE_ONE;
    end else begin
      score_d = best_val_d[SCORE_W-1:0];
    end
  end

  assign stat_o.map_end  = last_col && last_row;
  assign stat_o.out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      map_width_q  <= MAP_WIDTH_RST;
      map_height_q <= MAP_HEIGHT_RST;
      kp_count_q   <= KP_COUNT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_MAP_WIDTH:  map_width_q  <= cfg_wdata_i;
        REG_MAP_HEIGHT: map_height_q <= cfg_wdata_i;
        REG_KP_COUNT:   kp_count_q   <= cfg_wdata_i[KPCNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_col_q  <= '0;
      cur_row_q  <= '0;
      cur_kp_q   <= '0;
      best_val_q <= '0;
      best_col_q <= '0;
      best_row_q <= '0;
      nan_seen_q <= 1'b0;
    end else if (cmd_i.accept) begin
      best_val_q <= best_val_d;
      best_col_q <= best_col_d;
      best_row_q <= best_row_d;
      nan_seen_q <= nan_seen_d;
      if (!last_col) begin
        cur_col_q <= cur_col_q + POS_W'(1);
      end else begin
        cur_col_q <= '0;
        if (!last_row) begin
          cur_row_q <= cur_row_q + POS_W'(1);
        end else begin
          cur_row_q <= '0;
          cur_kp_q  <= last_kp ? '0 : cur_kp_q + KP_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      pend_kp_q    <= KPIDX_W'(cur_kp_q);
      pend_score_q <= score_d;
      pend_last_q  <= last_kp;
    end
  end

  hmad_div_lane #(
    .NUM_W(Q_W),
    .DEN_W(DIM_W)
  ) u_div_x (
    .clk_i  (clk_i),
    .start_i(cmd_i.start),
    .step_i (cmd_i.step),
    .num_i  ({best_col_d, FRAC_W'(0)}),
    .den_i  (eff_w[DIM_W-1:0]),
    .quo_o  (quo_x)
  );

  hmad_div_lane #(
    .NUM_W(Q_W),
    .DEN_W(DIM_W)
  ) u_div_y (
    .clk_i  (clk_i),
    .start_i(cmd_i.start),
    .step_i (cmd_i.step),
    .num_i  ({best_row_d, FRAC_W'(0)}),
    .den_i  (eff_h[DIM_W-1:0]),
    .quo_o  (quo_y)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // A position past a shrunken size saturates at the largest Q0.16 value.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      out_kp_q    <= pend_kp_q;
      out_score_q <= pend_score_q;
      out_last_q  <= pend_last_q;
      out_x_q     <= (quo_x[Q_W-1:FRAC_W] != '0) ? '1 : quo_x[FRAC_W-1:0];
      out_y_q     <= (quo_y[Q_W-1:FRAC_W] != '0) ? '1 : quo_y[FRAC_W-1:0];
    end
  end

  assign out_valid_o      = out_valid_q;
  assign keypoint_index_o = out_kp_q;
  assign score_o          = out_score_q;
  assign x_norm_o         = out_x_q;
  assign y_norm_o         = out_y_q;
  assign last_keypoint_o  = out_last_q;

  a_score_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_score_q <= SCORE_ONE))
    else $error("score above 1.0 presented");

  a_out_from_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(cmd_i.load))
    else $error("output became valid without a load command");

endmodule

### hdl/hmad_ctrl.sv
// ----------------------------------------------------------------------------
// Heatmap argmax decoder controller
// Sequences sample intake, the bit-serial divisions and the output load.
// ----------------------------------------------------------------------------
module hmad_ctrl #(
  parameter int unsigned MAX_MAP_DIM = hmad_pkg::MAX_MAP_DIM_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  hmad_pkg::hmad_stat_t stat_i,
  output hmad_pkg::hmad_cmd_t  cmd_o
);

  import hmad_pkg::*;

  localparam int unsigned Q_W    = $clog2(MAX_MAP_DIM) + FRAC_W;
  localparam int unsigned STEP_W = $clog2(Q_W);

  hmad_state_e       state_q, state_d;
  logic [STEP_W-1:0] step_q, step_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_RUN;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    step_d     = step_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    unique case (state_q)
      ST_RUN: begin
        in_ready_o   = 1'b1;
        cmd_o.accept = in_valid_i;
        if (in_valid_i && stat_i.map_end) begin
          cmd_o.start = 1'b1;
          step_d      = STEP_W'(Q_W - 1);
          state_d     = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd_o.step = 1'b1;
        if (step_q == '0) begin
          state_d = ST_LOAD;
        end else begin
          step_d = step_q - STEP_W'(1);
        end
      end
      ST_LOAD: begin
        if (stat_i.out_free) begin
          cmd_o.load = 1'b1;
          state_d    = ST_RUN;
        end
      end
      default: state_d = ST_RUN;
    endcase
  end

  a_start_divides: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.start |=> (state_q == ST_DIV) && (step_q == STEP_W'(Q_W - 1)))
    else $error("map end did not start the division");

  a_div_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV) && (step_q == '0) |=> (state_q == ST_LOAD))
    else $error("division did not finish after its last step");

  a_load_waits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_LOAD) && !stat_i.out_free |=> (state_q == ST_LOAD))
    else $error("result dropped while the output register was occupied");

endmodule

### hdl/planar_heatmap_argmax_decoder.sv
// A sample that ends a map captures its result and starts both dividers; when they
// have produced every quotient bit, the result moves into the output register once
// it is free. Throughput: one sample per cycle inside a map; each map end stalls
// intake while the dividers run, and longer while the output register is occupied.
// Reset: asynchronous, active low; clears the search state and counters and
// sets the sizes to 64 x 64 with 17 keypoints.
// ----------------------------------------------------------------------------
// Planar heatmap argmax decoder
// Finds the first maximum of each keypoint heatmap in a planar sample stream
// and reports its clamped score and normalized position.
// ----------------------------------------------------------------------------
module planar_heatmap_argmax_decoder #(
  parameter int unsigned MAX_MAP_DIM   = hmad_pkg::MAX_MAP_DIM_DEF,
  parameter int unsigned MAX_KEYPOINTS = hmad_pkg::MAX_KEYPOINTS_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // Configuration write port.
  input  logic                                 cfg_we_i,
  input  logic [hmad_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [hmad_pkg::CFG_W-1:0]           cfg_wdata_i,
  // Sample request channel.
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic signed [hmad_pkg::SAMPLE_W-1:0] sample_i,
  input  logic                                 sample_is_nan_i,
  // Result request channel.
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic [hmad_pkg::KPIDX_W-1:0]         keypoint_index_o,
  output logic [hmad_pkg::SCORE_W-1:0]         score_o,
  output logic [hmad_pkg::FRAC_W-1:0]          x_norm_o,
  output logic [hmad_pkg::FRAC_W-1:0]          y_norm_o,
  output logic                                 last_keypoint_o
);

  import hmad_pkg::*;

  // The controller only sequences: it takes a sample request in the run state,
  // and when the datapath reports that the sample closes a map it starts the
  // dividers, counts their steps and then waits until the output register is
  // free. The output register parts the two sides, so sample requests keep
  // flowing while an earlier result waits to be taken.
  hmad_cmd_t  cmd;
  hmad_stat_t stat;

  hmad_ctrl #(
    .MAX_MAP_DIM(MAX_MAP_DIM)
  ) u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .stat_i    (stat),
    .cmd_o     (cmd)
  );

  // The datapath holds the size registers, the row, column and keypoint
  // counters, the running maximum with its position and the not-a-number
  // freeze, and divides the position by the map size one bit per cycle.
  hmad_datapath #(
    .MAX_MAP_DIM  (MAX_MAP_DIM),
    .MAX_KEYPOINTS(MAX_KEYPOINTS)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .sample_i        (sample_i),
    .sample_is_nan_i (sample_is_nan_i),
    .out_ready_i     (out_ready_i),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .out_valid_o     (out_valid_o),
    .keypoint_index_o(keypoint_index_o),
    .score_o         (score_o),
    .x_norm_o        (x_norm_o),
    .y_norm_o        (y_norm_o),
    .last_keypoint_o (last_keypoint_o)
  );

endmodule
